### sv/skst_pkg.sv
`default_nettype none

package skst_pkg;

   localparam int SLOTS = 16;
   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   localparam int MODE_W   = 2;
   localparam int KEY_W    = 32;
   localparam int VALUE_W  = 64;
   localparam int FILE_W   = 32;
   localparam int LINE_W   = 32;
   localparam int CNT_W    = 5;
   localparam int STATUS_W = 2;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
   localparam logic [CNT_W-1:0] CNT_SAT  = {CNT_W{1'b1}};

   localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
   localparam logic [MODE_W-1:0] MODE_PUT    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;
   localparam logic [MODE_W-1:0] MODE_COUNT  = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_ABSENT = 2'd2;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

endpackage

`default_nettype wire

### sv/skst_req_if.sv
`default_nettype none

interface skst_req_if
   import skst_pkg::*;
   ();

   logic               valid;
   logic               ready;
   logic [MODE_W-1:0]  mode;
   logic [KEY_W-1:0]   key;
   logic [VALUE_W-1:0] value_in;
   logic [FILE_W-1:0]  file_in;
   logic [LINE_W-1:0]  line_in;

   modport source (output valid, mode, key, value_in, file_in, line_in, input ready);
   modport sink   (input valid, mode, key, value_in, file_in, line_in, output ready);

endinterface

`default_nettype wire

### sv/skst_rsp_if.sv
`default_nettype none

interface skst_rsp_if
   import skst_pkg::*;
   ();

   logic                valid;
   logic                ready;
   logic                found;
   logic [VALUE_W-1:0]  value_out;
   logic [FILE_W-1:0]   file_out;
   logic [LINE_W-1:0]   line_out;
   logic [CNT_W-1:0]    entry_count;
   logic [STATUS_W-1:0] status;

   modport source (output valid, found, value_out, file_out, line_out, entry_count, status,
                   input ready);
   modport sink   (input valid, found, value_out, file_out, line_out, entry_count, status,
                   output ready);

endinterface

`default_nettype wire

### sv/small_keyed_slot_table_unit.sv
`default_nettype none

// Keyed slot table with an in-order linear search over SLOTS entries.
// Request words arrive on req_ch (valid/ready): mode selects lookup, put,
// delete or count, and key, value_in, file_in, line_in carry the operands.
// Every request produces exactly one response word on rsp_ch (valid/ready).
//
// One slot is examined per clock by a single key comparator stepped by an
// index counter. A lookup, put or delete stops at the slot that decides it,
// so it scans k+1 slots when slot k decides and SLOTS slots otherwise; a
// count always scans all SLOTS slots. The response is registered on the edge
// that ends the scan, and the scanner then returns to idle before it accepts
// the next word.
//
// req_ch.ready is high only while the scanner is idle. The response register
// lets the next request be accepted and scanned while an earlier response
// waits; if the receiver still stalls when a scan ends, the scanner holds on
// its final slot without changing the table until the register frees up.
// Synchronous reset empties the table (all slots invalid) and drops any
// pending response; slot contents are not cleared.

module small_keyed_slot_table_unit
   import skst_pkg::*;
   (
   input  wire             clock,
   input  wire             reset,
   skst_req_if.sink        req_ch,
   skst_rsp_if.source      rsp_ch
   );

   state_type state_ff, state_in;

   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   logic [MODE_W-1:0]   mode_ff;
   logic [KEY_W-1:0]    key_ff;
   logic [VALUE_W-1:0]  value_ff;
   logic [FILE_W-1:0]   file_ff;
   logic [LINE_W-1:0]   line_ff;

   logic                slot_valid_ff [SLOTS];
   logic [KEY_W-1:0]    slot_key_ff   [SLOTS];
   logic [VALUE_W-1:0]  slot_value_ff [SLOTS];
   logic [FILE_W-1:0]   slot_file_ff  [SLOTS];
   logic [LINE_W-1:0]   slot_line_ff  [SLOTS];

   logic                rsp_valid_ff, rsp_valid_in;
   logic                found_ff, found_in;
   logic [VALUE_W-1:0]  value_out_ff, value_out_in;
   logic [FILE_W-1:0]   file_out_ff, file_out_in;
   logic [LINE_W-1:0]   line_out_ff, line_out_in;
   logic [CNT_W-1:0]    entry_count_ff, entry_count_in;
   logic [STATUS_W-1:0] status_ff, status_in;

   logic                req_accept;
   logic                cur_valid;
   logic                key_hit;
   logic                last_slot;
   logic                done;
   logic                out_free;
   logic                commit;
   logic                write_data;
   logic                clear_slot;
   logic [CNT_W-1:0]    count_step;

   // Slot under the comparator.
   assign cur_valid  = slot_valid_ff[idx_ff];
   assign key_hit    = cur_valid && (slot_key_ff[idx_ff] == key_ff);
   assign last_slot  = (idx_ff == LAST_IDX);
   assign count_step = (cur_valid && (count_ff != CNT_SAT)) ? count_ff + 1'b1 : count_ff;

   assign req_accept = req_ch.valid && req_ch.ready;
   assign out_free   = !rsp_valid_ff || rsp_ch.ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (commit) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs and the result of the current step.
   always_comb begin
      req_ch.ready   = (state_ff == ST_IDLE);
      done           = 1'b0;
      found_in       = 1'b0;
      value_out_in   = '0;
      file_out_in    = '0;
      line_out_in    = '0;
      entry_count_in = '0;
      status_in      = STATUS_OK;

      unique case (mode_ff)
         MODE_LOOKUP: begin
            done     = key_hit || last_slot;
            found_in = key_hit;
            if (key_hit) begin
               value_out_in = slot_value_ff[idx_ff];
               file_out_in  = slot_file_ff[idx_ff];
               line_out_in  = slot_line_ff[idx_ff];
            end
         end
         MODE_PUT: begin
            // An empty slot wins over any later match.
            done     = !cur_valid || key_hit || last_slot;
            found_in = key_hit;
            if (cur_valid && !key_hit) begin
               status_in = STATUS_FULL;
            end
         end
         MODE_DELETE: begin
            done     = key_hit || last_slot;
            found_in = key_hit;
            if (!key_hit) begin
               status_in = STATUS_ABSENT;
            end
         end
         MODE_COUNT: begin
            done           = last_slot;
            entry_count_in = count_step;
         end
         default: done = 1'b1;
      endcase

      commit     = (state_ff == ST_SCAN) && done && out_free;
      write_data = commit && (mode_ff == MODE_PUT) && (!cur_valid || key_hit);
      clear_slot = commit && (mode_ff == MODE_DELETE) && key_hit;
   end

   always_comb begin
      idx_in   = idx_ff;
      count_in = count_ff;
      if (req_accept) begin
         idx_in   = '0;
         count_in = '0;
      end else if ((state_ff == ST_SCAN) && !done) begin
         idx_in   = IDX_W'(idx_ff + 1'b1);
         count_in = count_step;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            slot_valid_ff[i] <= 1'b0;
         end
      end else if (write_data) begin
         slot_valid_ff[idx_ff] <= 1'b1;
      end else if (clear_slot) begin
         slot_valid_ff[idx_ff] <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (write_data) begin
         slot_key_ff[idx_ff]   <= key_ff;
         slot_value_ff[idx_ff] <= value_ff;
         slot_file_ff[idx_ff]  <= file_ff;
         slot_line_ff[idx_ff]  <= line_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         mode_ff  <= req_ch.mode;
         key_ff   <= req_ch.key;
         value_ff <= req_ch.value_in;
         file_ff  <= req_ch.file_in;
         line_ff  <= req_ch.line_in;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         found_ff       <= found_in;
         value_out_ff   <= value_out_in;
         file_out_ff    <= file_out_in;
         line_out_ff    <= line_out_in;
         entry_count_ff <= entry_count_in;
         status_ff      <= status_in;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.found       = found_ff;
   assign rsp_ch.value_out   = value_out_ff;
   assign rsp_ch.file_out    = file_out_ff;
   assign rsp_ch.line_out    = line_out_ff;
   assign rsp_ch.entry_count = entry_count_ff;
   assign rsp_ch.status      = status_ff;

   // A newly accepted word always starts scanning at the first slot.
   a_scan_start: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_SCAN) && (idx_ff == '0))
      else $error("scan did not start at slot zero");

   // A delete that hits leaves the slot it hit empty.
   a_delete_clears: assert property (@(posedge clock) disable iff (reset)
      clear_slot |=> !slot_valid_ff[$past(idx_ff)])
      else $error("deleted slot still valid");

   // Any response word that reports a hit (lookup, put or delete) reports ok.
   a_hit_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && found_ff) |-> (status_ff == STATUS_OK))
      else $error("hit reported with a failure status");

   // The table never changes while a finished result cannot be delivered.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SCAN) && !out_free) |-> !write_data && !clear_slot)
      else $error("table written while the response register was full");

endmodule

`default_nettype wire

### tb/tb_small_keyed_slot_table_unit.sv
module tb_small_keyed_slot_table_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import skst_pkg::*;

   localparam int WATCHDOG_LIMIT  = 1000;
   localparam int TAIL_CYCLES     = 2 * SLOTS + 8;
   localparam int PHASES          = 10;
   localparam int ITEMS_PER_PHASE = 85;
   localparam int KEY_POOL        = 32;
   localparam int FILL_PUTS       = 20;
   localparam int REPORT_LIMIT    = 10;

   localparam logic [KEY_W-1:0]   KEY_ONES   = '1;
   localparam logic [VALUE_W-1:0] VALUE_ONES = '1;
   localparam logic [FILE_W-1:0]  FILE_ONES  = '1;
   localparam logic [LINE_W-1:0]  LINE_ONES  = '1;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
      logic [FILE_W-1:0]  file;
      logic [LINE_W-1:0]  line;
   } table_op_type;

   typedef struct packed {
      logic                found;
      logic [VALUE_W-1:0]  value;
      logic [FILE_W-1:0]   file;
      logic [LINE_W-1:0]   line;
      logic [CNT_W-1:0]    count;
      logic [STATUS_W-1:0] status;
   } table_reply_type;

   typedef struct {
      table_op_type    op;
      bit              typed;
      table_reply_type reply;
   } directed_row_type;

   logic clock;
   logic reset;

   skst_req_if req_ch ();
   skst_rsp_if rsp_ch ();

   small_keyed_slot_table_unit u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // A directed row with a hand-written reply overrides the predicted one.
   bit              op_typed;
   table_reply_type op_typed_reply;

   // Shadow copy of the slot table.
   bit                 tbl_used  [SLOTS];
   logic [KEY_W-1:0]   tbl_key   [SLOTS];
   logic [VALUE_W-1:0] tbl_value [SLOTS];
   logic [FILE_W-1:0]  tbl_file  [SLOTS];
   logic [LINE_W-1:0]  tbl_line  [SLOTS];

   table_reply_type  expected_replies [$];
   directed_row_type directed_rows [$];
   logic [KEY_W-1:0] key_pool  [KEY_POOL];
   logic [KEY_W-1:0] fill_keys [FILL_PUTS];

   int  words_sent;
   int  replies_seen;
   int  mismatch_count;
   int  idle_cycles;
   bit  no_idle;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic table_reply_type apply_table_op(table_op_type op);
      table_reply_type reply;
      int              hit;
      int              used;
      bit              placed;
      reply  = '0;
      hit    = -1;
      used   = 0;
      placed = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
         if (hit < 0 && tbl_used[i] && tbl_key[i] == op.key) hit = i;
         if (tbl_used[i]) used++;
      end
      case (op.mode)
         MODE_LOOKUP: begin
            if (hit >= 0) begin
               reply.found = 1'b1;
               reply.value = tbl_value[hit];
               reply.file  = tbl_file[hit];
               reply.line  = tbl_line[hit];
            end
         end
         MODE_PUT: begin
            // The first empty slot wins over any later slot with the same key.
            reply.status = STATUS_FULL;
            for (int i = 0; i < SLOTS; i++) begin
               if (!placed && (!tbl_used[i] || tbl_key[i] == op.key)) begin
                  reply.found  = tbl_used[i];
                  reply.status = STATUS_OK;
                  tbl_used[i]  = 1'b1;
                  tbl_key[i]   = op.key;
                  tbl_value[i] = op.value;
                  tbl_file[i]  = op.file;
                  tbl_line[i]  = op.line;
                  placed       = 1'b1;
               end
            end
         end
         MODE_DELETE: begin
            if (hit >= 0) begin
               tbl_used[hit] = 1'b0;
               reply.found   = 1'b1;
            end else begin
               reply.status = STATUS_ABSENT;
            end
         end
         default: begin
            if (used > int'(CNT_SAT)) used = int'(CNT_SAT);
            reply.count = CNT_W'(used);
         end
      endcase
      return reply;
   endfunction

   function automatic table_reply_type reply_of(logic found, logic [VALUE_W-1:0] value,
                                                logic [FILE_W-1:0] file,
                                                logic [LINE_W-1:0] line,
                                                logic [CNT_W-1:0] count,
                                                logic [STATUS_W-1:0] status);
      table_reply_type reply;
      reply.found  = found;
      reply.value  = value;
      reply.file   = file;
      reply.line   = line;
      reply.count  = count;
      reply.status = status;
      return reply;
   endfunction

   function automatic directed_row_type row(logic [MODE_W-1:0] mode, logic [KEY_W-1:0] key,
                                            logic [VALUE_W-1:0] value,
                                            logic [FILE_W-1:0] file,
                                            logic [LINE_W-1:0] line, bit typed,
                                            table_reply_type reply);
      directed_row_type r;
      r.op.mode  = mode;
      r.op.key   = key;
      r.op.value = value;
      r.op.file  = file;
      r.op.line  = line;
      r.typed    = typed;
      r.reply    = reply;
      return r;
   endfunction

   function automatic table_op_type random_op(int pool_size, int put_pct, int look_pct,
                                              int del_pct);
      table_op_type op;
      int           pick;
      pick = $urandom_range(0, 99);
      if (pick < put_pct)                          op.mode = MODE_PUT;
      else if (pick < put_pct + look_pct)          op.mode = MODE_LOOKUP;
      else if (pick < put_pct + look_pct + del_pct) op.mode = MODE_DELETE;
      else                                         op.mode = MODE_COUNT;
      // A pool size of zero means wide keys, half of them fresh.
      if (pool_size == 0 && $urandom_range(0, 1) == 1)
         op.key = $urandom;
      else if (pool_size == 0)
         op.key = key_pool[$urandom_range(0, KEY_POOL - 1)];
      else
         op.key = key_pool[$urandom_range(0, pool_size - 1)];
      op.value = {$urandom, $urandom};
      op.file  = $urandom;
      op.line  = $urandom;
      case ($urandom_range(0, 15))
         0: begin
            op.value = '0;
            op.file  = '0;
            op.line  = '0;
         end
         1: begin
            op.value = VALUE_ONES;
            op.file  = FILE_ONES;
            op.line  = LINE_ONES;
         end
         default: ;
      endcase
      return op;
   endfunction

   function automatic int idle_gap(int longest);
      int pick;
      if (no_idle) return 0;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 85) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 12);
      return $urandom_range(20, longest);
   endfunction

   task automatic note_mismatch(bit has_want, table_reply_type want, table_reply_type got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         if (has_want)
            $display("mismatch: expected found=%0d value=%h file=%h line=%h count=%0d status=%0d",
                     want.found, want.value, want.file, want.line, want.count, want.status);
         else
            $display("mismatch: response word with nothing outstanding");
         $display("          got      found=%0d value=%h file=%h line=%h count=%0d status=%0d",
                  got.found, got.value, got.file, got.line, got.count, got.status);
      end
   endtask

   task automatic drive_word(table_op_type op, bit typed = 1'b0, table_reply_type reply = '0);
      int gap;
      gap = idle_gap(40);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.mode     <= op.mode;
      req_ch.key      <= op.key;
      req_ch.value_in <= op.value;
      req_ch.file_in  <= op.file;
      req_ch.line_in  <= op.line;
      op_typed        <= typed;
      op_typed_reply  <= reply;
      do @(posedge clock); while (!req_ch.ready);
      words_sent++;
   endtask

   // Called right after an accepted word, so the word must be withdrawn here.
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (replies_seen != words_sent) @(posedge clock);
   endtask

   // Scoreboard and watchdog.
   always @(posedge clock) begin
      table_op_type    op;
      table_reply_type want;
      table_reply_type got;
      bit              moved;
      if (!reset) begin
         moved = 1'b0;
         if (req_ch.valid && req_ch.ready) begin
            op.mode  = req_ch.mode;
            op.key   = req_ch.key;
            op.value = req_ch.value_in;
            op.file  = req_ch.file_in;
            op.line  = req_ch.line_in;
            want     = apply_table_op(op);
            if (op_typed) want = op_typed_reply;
            expected_replies.push_back(want);
            moved = 1'b1;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.found  = rsp_ch.found;
            got.value  = rsp_ch.value_out;
            got.file   = rsp_ch.file_out;
            got.line   = rsp_ch.line_out;
            got.count  = rsp_ch.entry_count;
            got.status = rsp_ch.status;
            replies_seen++;
            moved = 1'b1;
            if (expected_replies.size() == 0) begin
               note_mismatch(1'b0, '0, got);
            end else begin
               want = expected_replies.pop_front();
               if (got !== want) note_mismatch(1'b1, want, got);
            end
         end
         if (moved) idle_cycles = 0;
         else       idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   // Response side: random stalls with occasional long ones, none while no_idle is set.
   initial begin
      int stall;
      forever begin
         stall = idle_gap(60);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         repeat (no_idle ? 20 : $urandom_range(1, 6)) @(posedge clock);
      end
   end

   initial begin
      table_op_type op;
      int           kind;
      reset           <= 1'b1;
      req_ch.valid    <= 1'b0;
      req_ch.mode     <= MODE_LOOKUP;
      req_ch.key      <= '0;
      req_ch.value_in <= '0;
      req_ch.file_in  <= '0;
      req_ch.line_in  <= '0;
      op_typed        <= 1'b0;
      op_typed_reply  <= '0;
      no_idle         = 1'b0;
      words_sent      = 0;
      replies_seen    = 0;
      mismatch_count  = 0;
      idle_cycles     = 0;
      key_pool[0]     = '0;
      key_pool[1]     = KEY_ONES;
      for (int i = 2; i < KEY_POOL; i++) key_pool[i] = $urandom;

      // Slots referred to below are the ones the scan order picks.
      directed_rows.push_back(row(MODE_COUNT, '0, '0, '0, '0, 1,
                              reply_of(0, '0, '0, '0, 0, STATUS_OK)));
      directed_rows.push_back(row(MODE_LOOKUP, '0, '0, '0, '0, 1,
                              reply_of(0, '0, '0, '0, 0, STATUS_OK)));
      directed_rows.push_back(row(MODE_DELETE, KEY_ONES, '0, '0, '0, 1,
                              reply_of(0, '0, '0, '0, 0, STATUS_ABSENT)));
      directed_rows.push_back(row(MODE_PUT, '0, VALUE_ONES, FILE_ONES, LINE_ONES, 1,
                              reply_of(0, '0, '0, '0, 0, STATUS_OK)));
      directed_rows.push_back(row(MODE_LOOKUP, '0, '0, '0, '0, 1,
                              reply_of(1, VALUE_ONES, FILE_ONES, LINE_ONES, 0, STATUS_OK)));
      directed_rows.push_back(row(MODE_PUT, KEY_ONES, '0, '0, '0, 1,
                              reply_of(0, '0, '0, '0, 0, STATUS_OK)));
      directed_rows.push_back(row(MODE_LOOKUP, KEY_ONES, VALUE_ONES, FILE_ONES, LINE_ONES, 1,
                              reply_of(1, '0, '0, '0, 0, STATUS_OK)));
      directed_rows.push_back(row(MODE_PUT, '0, 64'h0123_4567_89ab_cdef, 32'h89ab_cdef,
                              32'h7654_3210, 1, reply_of(1, '0, '0, '0, 0, STATUS_OK)));
      directed_rows.push_back(row(MODE_LOOKUP, '0, '0, '0, '0, 0, '0));
      directed_rows.push_back(row(MODE_PUT, 32'h5555_aaaa, 64'haaaa_5555_aaaa_5555,
                              32'h5555_aaaa, 32'haaaa_5555, 0, '0));
      directed_rows.push_back(row(MODE_COUNT, '0, '0, '0, '0, 1,
                              reply_of(0, '0, '0, '0, 3, STATUS_OK)));
      directed_rows.push_back(row(MODE_DELETE, '0, '0, '0, '0, 1,
                              reply_of(1, '0, '0, '0, 0, STATUS_OK)));
      directed_rows.push_back(row(MODE_LOOKUP, '0, VALUE_ONES, '0, '0, 1,
                              reply_of(0, '0, '0, '0, 0, STATUS_OK)));
      // The freed first slot takes a second copy of a key that is still stored.
      directed_rows.push_back(row(MODE_PUT, KEY_ONES, 64'h1, 32'h2, 32'h3, 1,
                              reply_of(0, '0, '0, '0, 0, STATUS_OK)));
      directed_rows.push_back(row(MODE_LOOKUP, KEY_ONES, '0, '0, '0, 0, '0));
      directed_rows.push_back(row(MODE_COUNT, KEY_ONES, '0, '0, '0, 1,
                              reply_of(0, '0, '0, '0, 3, STATUS_OK)));
      directed_rows.push_back(row(MODE_DELETE, KEY_ONES, '0, '0, '0, 1,
                              reply_of(1, '0, '0, '0, 0, STATUS_OK)));
      directed_rows.push_back(row(MODE_LOOKUP, KEY_ONES, '0, '0, '0, 0, '0));
      directed_rows.push_back(row(MODE_DELETE, KEY_ONES, '0, '0, '0, 1,
                              reply_of(1, '0, '0, '0, 0, STATUS_OK)));
      directed_rows.push_back(row(MODE_DELETE, KEY_ONES, '0, '0, '0, 1,
                              reply_of(0, '0, '0, '0, 0, STATUS_ABSENT)));
      directed_rows.push_back(row(MODE_LOOKUP, 32'h5555_aaaa, VALUE_ONES, FILE_ONES,
                              LINE_ONES, 0, '0));
      directed_rows.push_back(row(MODE_DELETE, 32'h5555_aaaa, '0, '0, '0, 0, '0));
      directed_rows.push_back(row(MODE_COUNT, '0, '0, '0, '0, 1,
                              reply_of(0, '0, '0, '0, 0, STATUS_OK)));

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         drive_word(directed_rows[i].op, directed_rows[i].typed, directed_rows[i].reply);

      // Hold the sender off until the table has answered everything.
      wait_drained();

      for (int phase = 0; phase < PHASES; phase++) begin
         kind    = phase % 5;
         no_idle = (phase % 4 == 3);
         case (kind)
            0: repeat (ITEMS_PER_PHASE) drive_word(random_op(4, 35, 35, 20));
            1: repeat (ITEMS_PER_PHASE) drive_word(random_op(24, 60, 20, 12));
            2: begin
               // Fill past capacity with fresh keys, probe them, then delete each of those keys again.
               for (int i = 0; i < FILL_PUTS; i++) begin
                  op     = random_op(0, 100, 0, 0);
                  op.key = $urandom;
                  fill_keys[i] = op.key;
                  drive_word(op);
               end
               repeat (15) begin
                  op = random_op(0, 0, 80, 0);
                  if (op.mode == MODE_LOOKUP) op.key = fill_keys[$urandom_range(0, FILL_PUTS - 1)];
                  drive_word(op);
               end
               for (int i = 0; i < FILL_PUTS; i++) begin
                  op     = random_op(0, 0, 0, 100);
                  op.key = fill_keys[i];
                  drive_word(op);
               end
               repeat (ITEMS_PER_PHASE - 2 * FILL_PUTS - 15)
                  drive_word(random_op(KEY_POOL, 40, 30, 20));
            end
            3: repeat (ITEMS_PER_PHASE) drive_word(random_op(0, 35, 35, 20));
            default: repeat (ITEMS_PER_PHASE) drive_word(random_op(KEY_POOL, 30, 30, 30));
         endcase
         if (phase == PHASES / 2) wait_drained();
      end

      no_idle = 1'b0;
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_replies.size() != 0) begin
         mismatch_count++;
         $display("mismatch: %0d response words never arrived", expected_replies.size());
      end
      if (mismatch_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
